### rtl/nmcl_pkg.sv
// Package for the nonuniform mesh cell locator: widths, request codes and
// controller-to-datapath command and status types. No dependencies.
`default_nettype none
package nmcl_pkg;
  localparam int MaxCells   = 1024;
  localparam int CoordBits  = 32;
  localparam int FracBits   = 16;
  localparam int IdxBits    = $clog2(MaxCells);      // 10
  localparam int CntBits    = IdxBits + 1;           // 11
  localparam int NodeDepth  = MaxCells + 1;
  localparam int NodeAddrW  = $clog2(NodeDepth);     // 11
  localparam int FracCntW   = $clog2(FracBits + 1);

  localparam logic [1:0] ReqNode   = 2'd0;
  localparam logic [1:0] ReqWidth  = 2'd1;
  localparam logic [1:0] ReqLocate = 2'd2;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch locate position
    logic       axis_start; // init search of current axis
    logic       rd_bounds0; // read node 0
    logic       rd_boundsn; // read node n
    logic       chk_low;    // compare against node 0
    logic       chk_high;   // compare against node n
    logic       rd_mid;     // read node at mid
    logic       step;       // apply probe result
    logic       rd_base;    // read node lo and width lo
    logic       div_init;   // set up division
    logic       div_step;   // one quotient bit
    logic       axis_done;  // store axis result
    logic       clear_res;  // zero result (outside)
    logic [1:0] axis;
  } nmcl_cmd_t;

  // Status bundle from the datapath to the controller.
  typedef struct packed {
    logic outside;     // last bounds check failed
    logic search_done; // hi == lo + 1
    logic div_done;    // all quotient bits produced, or saturated or zero
  } nmcl_sts_t;
endpackage
`default_nettype wire

### rtl/nmcl_datapath.sv
// Datapath: node and width memories, binary search registers, divider.
// Depends on nmcl_pkg.
`default_nettype none
module nmcl_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  wr_en_i,
  input  wire  [1:0]                           wr_type_i,
  input  wire  [1:0]                           wr_axis_i,
  input  wire  [nmcl_pkg::NodeAddrW-1:0]       wr_idx_i,
  input  wire  [nmcl_pkg::CoordBits-1:0]       wr_val_i,
  input  wire  [nmcl_pkg::CntBits-1:0]         cells_x_i,
  input  wire  [nmcl_pkg::CntBits-1:0]         cells_y_i,
  input  wire  [nmcl_pkg::CntBits-1:0]         cells_z_i,
  input  wire  [nmcl_pkg::CoordBits-1:0]       pos_x_i,
  input  wire  [nmcl_pkg::CoordBits-1:0]       pos_y_i,
  input  wire  [nmcl_pkg::CoordBits-1:0]       pos_z_i,
  input  nmcl_pkg::nmcl_cmd_t                  cmd_i,
  output nmcl_pkg::nmcl_sts_t                  sts_o,
  output logic                                 inside_o,
  output logic [nmcl_pkg::IdxBits-1:0]         cell_x_o,
  output logic [nmcl_pkg::FracBits:0]          frac_x_o,
  output logic [nmcl_pkg::IdxBits-1:0]         cell_y_o,
  output logic [nmcl_pkg::FracBits:0]          frac_y_o,
  output logic [nmcl_pkg::IdxBits-1:0]         cell_z_o,
  output logic [nmcl_pkg::FracBits:0]          frac_z_o
);
  import nmcl_pkg::*;

  localparam logic [CoordBits-1:0] SignBit = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic [FracBits:0]    One     = {1'b1, {FracBits{1'b0}}};

  logic [CoordBits-1:0] node_mem [3][NodeDepth];
  logic [CoordBits-1:0] width_mem[3][MaxCells];
  logic [CoordBits-1:0] node_rd_q, width_rd_q;
  logic [NodeAddrW-1:0] node_addr;
  logic [1:0]           rd_axis;

  logic [CoordBits-1:0] pos_q [3];
  logic [CoordBits-1:0] key_q;
  logic [CntBits-1:0]   n_q, lo_q, hi_q, mid;
  logic                 outside_q;
  logic [CoordBits:0]   rem_q;
  logic [CoordBits-1:0] w_q;
  logic [FracBits-1:0]  quo_q;
  logic [FracCntW-1:0]  dcnt_q;
  logic                 sat_q, zero_q;
  logic [CntBits-1:0]   n_sel;

  // Cell count in use, clamped to 1..MaxCells.
  always_comb begin
    case (cmd_i.axis)
      AxisX:   n_sel = cells_x_i;
      AxisY:   n_sel = cells_y_i;
      default: n_sel = cells_z_i;
    endcase
    if (n_sel == '0) n_sel = CntBits'(1);
    else if (n_sel > CntBits'(MaxCells)) n_sel = CntBits'(MaxCells);
  end

  assign mid = CntBits'((CntBits+1)'(lo_q) + (CntBits+1)'(hi_q) >> 1);

  // Memory read address selection.
  always_comb begin
    if (cmd_i.rd_bounds0)      node_addr = '0;
    else if (cmd_i.rd_boundsn) node_addr = NodeAddrW'(n_q);
    else if (cmd_i.rd_mid)     node_addr = NodeAddrW'(mid);
    else                       node_addr = NodeAddrW'(lo_q);
  end
  assign rd_axis = cmd_i.axis;

  // Table writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_type_i == ReqNode && wr_axis_i != 2'd3 &&
        wr_idx_i <= NodeAddrW'(MaxCells))
      node_mem[wr_axis_i][wr_idx_i] <= wr_val_i;
    if (wr_en_i && wr_type_i == ReqWidth && wr_axis_i != 2'd3 &&
        wr_idx_i < NodeAddrW'(MaxCells))
      width_mem[wr_axis_i][wr_idx_i[IdxBits-1:0]] <= wr_val_i;
    if (rd_axis != 2'd3) begin
      node_rd_q  <= node_mem[rd_axis][node_addr];
      width_rd_q <= width_mem[rd_axis][lo_q[IdxBits-1:0]];
    end
  end

  // Search, bounds check and division registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      n_q       <= '0;
      dcnt_q    <= '0;
    end else begin
      if (cmd_i.capture) begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
      end
      if (cmd_i.axis_start) begin
        n_q       <= n_sel;
        lo_q      <= '0;
        hi_q      <= n_sel;
        outside_q <= 1'b0;
        key_q     <= pos_q[cmd_i.axis] ^ SignBit;
      end
      if (cmd_i.chk_low)  outside_q <= key_q < (node_rd_q ^ SignBit);
      if (cmd_i.chk_high) outside_q <= key_q > (node_rd_q ^ SignBit);
      if (cmd_i.step) begin
        if (key_q < (node_rd_q ^ SignBit)) hi_q <= mid;
        else                               lo_q <= mid;
      end
      if (cmd_i.div_init) begin
        zero_q <= key_q <= (node_rd_q ^ SignBit);
        rem_q  <= {1'b0, key_q - (node_rd_q ^ SignBit)};
        w_q    <= width_rd_q;
        sat_q  <= (width_rd_q == '0) || width_rd_q[CoordBits-1] ||
                  (key_q - (node_rd_q ^ SignBit) >= width_rd_q);
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        if ({rem_q[CoordBits-1:0], 1'b0} >= {1'b0, w_q}) begin
          rem_q <= {rem_q[CoordBits-1:0], 1'b0} - {1'b0, w_q};
          quo_q <= {quo_q[FracBits-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[CoordBits-1:0], 1'b0};
          quo_q <= {quo_q[FracBits-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + FracCntW'(1);
      end
    end
  end

  assign sts_o.outside     = outside_q;
  assign sts_o.search_done = (hi_q == lo_q + CntBits'(1));
  assign sts_o.div_done    = (dcnt_q == FracCntW'(FracBits)) || sat_q || zero_q;

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_o <= 1'b0;
      cell_x_o <= '0; cell_y_o <= '0; cell_z_o <= '0;
      frac_x_o <= '0; frac_y_o <= '0; frac_z_o <= '0;
    end else if (cmd_i.capture) begin
      inside_o <= 1'b1;
    end else if (cmd_i.clear_res) begin
      inside_o <= 1'b0;
      cell_x_o <= '0; cell_y_o <= '0; cell_z_o <= '0;
      frac_x_o <= '0; frac_y_o <= '0; frac_z_o <= '0;
    end else if (cmd_i.axis_done) begin
      case (cmd_i.axis)
        AxisX: begin
          cell_x_o <= lo_q[IdxBits-1:0];
          frac_x_o <= zero_q ? '0 : sat_q ? One : {1'b0, quo_q};
        end
        AxisY: begin
          cell_y_o <= lo_q[IdxBits-1:0];
          frac_y_o <= zero_q ? '0 : sat_q ? One : {1'b0, quo_q};
        end
        default: begin
          cell_z_o <= lo_q[IdxBits-1:0];
          frac_z_o <= zero_q ? '0 : sat_q ? One : {1'b0, quo_q};
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/nmcl_ctrl.sv
// Controller state machine sequencing search and division per axis.
// Depends on nmcl_pkg.
`default_nettype none
module nmcl_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire                  out_taken_i,
  input  nmcl_pkg::nmcl_sts_t  sts_i,
  output nmcl_pkg::nmcl_cmd_t  cmd_o,
  output logic                 busy_o,
  output logic                 out_valid_o
);
  import nmcl_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit  = 4'd1;
  localparam logic [3:0] StRdLo  = 4'd2;
  localparam logic [3:0] StChkLo = 4'd3;
  localparam logic [3:0] StChkHi = 4'd4;
  localparam logic [3:0] StTest  = 4'd5;
  localparam logic [3:0] StRdMid = 4'd6;
  localparam logic [3:0] StStep  = 4'd7;
  localparam logic [3:0] StRdB   = 4'd8;
  localparam logic [3:0] StDivI  = 4'd9;
  localparam logic [3:0] StDiv   = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;
  localparam logic [3:0] StRdHi  = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= AxisX;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    case (state_q)
      StIdle: if (start_i) begin
        cmd_o.capture = 1'b1;
        axis_d  = AxisX;
        state_d = StInit;
      end
      StInit: begin
        cmd_o.axis_start = 1'b1;
        state_d = StRdLo;
      end
      StRdLo: begin
        cmd_o.rd_bounds0 = 1'b1;
        state_d = StChkLo;
      end
      StChkLo: begin
        cmd_o.chk_low = 1'b1;
        state_d = StRdHi;
      end
      StRdHi: begin
        if (sts_i.outside) begin
          cmd_o.clear_res = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.rd_boundsn = 1'b1;
          state_d = StChkHi;
        end
      end
      StChkHi: begin
        cmd_o.chk_high = 1'b1;
        state_d = StTest;
      end
      StTest: begin
        if (sts_i.outside) begin
          cmd_o.clear_res = 1'b1;
          state_d = StOut;
        end else if (sts_i.search_done) begin
          state_d = StRdB;
        end else begin
          state_d = StRdMid;
        end
      end
      StRdMid: begin
        cmd_o.rd_mid = 1'b1;
        state_d = StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        state_d = StTest;
      end
      StRdB: begin
        cmd_o.rd_base = 1'b1;
        state_d = StDivI;
      end
      StDivI: begin
        cmd_o.div_init = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StDone;
        else cmd_o.div_step = 1'b1;
      end
      StDone: begin
        cmd_o.axis_done = 1'b1;
        if (axis_q == AxisZ) begin
          state_d = StOut;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = StInit;
        end
      end
      StOut: if (out_taken_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
endmodule
`default_nettype wire

### rtl/nonuniform_mesh_cell_locator_core.sv
// Top level of the nonuniform mesh cell locator: config registers,
// request decode, controller and datapath. Depends on nmcl_pkg, nmcl_ctrl and nmcl_datapath.
//
//  channel | direction | handshake
//  request | in        | in_valid_i / in_stall_o
//  result  | out       | out_valid_o / out_stall_i
//  config  | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// Load requests write their table entry when taken. A locate walks the axes in turn:
// per axis setup and bounds checks, a test, a read and a step per search probe (10
// probes for 1024 cells), then the base read, divider setup, up to 16 quotient steps,
// the final check and the store, paced by the single shared node memory read port
// and the one-bit-a-step divider. Reset sets the cell counts to 1 and clears control
// and result registers; tables are undefined until loaded. The result holds while
// out_stall_i is high and no new request is taken until it leaves.
`default_nettype none
module nonuniform_mesh_cell_locator_core (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [1:0]                            cfg_idx_i,
  input  wire  [nmcl_pkg::CntBits-1:0]          cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [1:0]                            req_type_i,
  input  wire  [1:0]                            axis_i,
  input  wire  [nmcl_pkg::NodeAddrW-1:0]        entry_index_i,
  input  wire  signed [nmcl_pkg::CoordBits-1:0] load_value_i,
  input  wire  signed [nmcl_pkg::CoordBits-1:0] pos_x_i,
  input  wire  signed [nmcl_pkg::CoordBits-1:0] pos_y_i,
  input  wire  signed [nmcl_pkg::CoordBits-1:0] pos_z_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  inside_res_o,
  output logic [nmcl_pkg::IdxBits-1:0]          cell_x_o,
  output logic [nmcl_pkg::FracBits:0]           frac_x_o,
  output logic [nmcl_pkg::IdxBits-1:0]          cell_y_o,
  output logic [nmcl_pkg::FracBits:0]           frac_y_o,
  output logic [nmcl_pkg::IdxBits-1:0]          cell_z_o,
  output logic [nmcl_pkg::FracBits:0]           frac_z_o
);
  import nmcl_pkg::*;

  logic [CntBits-1:0] cells_q [3];
  nmcl_cmd_t cmd;
  nmcl_sts_t sts;
  logic busy, accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q[0] <= CntBits'(1);
      cells_q[1] <= CntBits'(1);
      cells_q[2] <= CntBits'(1);
    end else if (cfg_we_i && cfg_idx_i != 2'd3) begin
      cells_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  nmcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && req_type_i == ReqLocate),
    .out_taken_i (!out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  nmcl_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_type_i (req_type_i),
    .wr_axis_i (axis_i),
    .wr_idx_i  (entry_index_i),
    .wr_val_i  (load_value_i),
    .cells_x_i (cells_q[0]),
    .cells_y_i (cells_q[1]),
    .cells_z_i (cells_q[2]),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .pos_z_i   (pos_z_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .inside_o  (inside_res_o),
    .cell_x_o  (cell_x_o),
    .frac_x_o  (frac_x_o),
    .cell_y_o  (cell_y_o),
    .frac_y_o  (frac_y_o),
    .cell_z_o  (cell_z_o),
    .frac_z_o  (frac_z_o)
  );
endmodule
`default_nettype wire

### tb/sv/tb_nonuniform_mesh_cell_locator_core.sv
// Self-checking testbench for nonuniform_mesh_cell_locator_core: loads mesh tables,
// locates positions and compares every result with a built-in predictor.
// Depends on nmcl_pkg and the core RTL only.
`default_nettype none
module tb_nonuniform_mesh_cell_locator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import nmcl_pkg::*;

  localparam logic [16:0] FracOne = 17'h10000;
  localparam int NumPhases = 6;
  localparam int ItemsPerPhase = 48;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  axis;
    logic [10:0] idx;
    logic [31:0] val;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } request_t;

  typedef struct {
    logic        in_mesh;
    logic [9:0]  cell_x;
    logic [16:0] frac_x;
    logic [9:0]  cell_y;
    logic [16:0] frac_y;
    logic [9:0]  cell_z;
    logic [16:0] frac_z;
  } location_t;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  axis;
    logic [10:0] idx;
    logic [31:0] val;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;
    location_t   loc;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [1:0]  axis_i = '0;
  logic [10:0] entry_index_i = '0;
  logic [31:0] load_value_i = '0;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] pos_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        inside_res_o;
  logic [9:0]  cell_x_o, cell_y_o, cell_z_o;
  logic [16:0] frac_x_o, frac_y_o, frac_z_o;

  nonuniform_mesh_cell_locator_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .axis_i, .entry_index_i, .load_value_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .out_valid_o, .out_stall_i, .inside_res_o,
    .cell_x_o, .frac_x_o, .cell_y_o, .frac_y_o, .cell_z_o, .frac_z_o
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block's tables and cell counts.
  logic [31:0] node_tbl [3][MaxCells+1];
  logic [31:0] width_tbl [3][MaxCells];
  logic [10:0] cells_cfg [3];

  location_t pending_locations [$];
  int unsigned error_count = 0;
  bit sender_noisy = 1'b1;
  bit receiver_noisy = 1'b1;
  bit long_hold_req = 1'b0;
  int unsigned hold_left = 0;

  // Directed rows: boundaries, full-range axis, zero and negative widths, ignored loads.
  directed_row_t directed_rows [24] = '{
    '{ReqNode,  AxisX, 11'd0, 32'h8000_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisX, 11'd1, 32'h7FFF_FFFF, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqWidth, AxisX, 11'd0, 32'h7FFF_FFFF, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisY, 11'd0, 32'h0000_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisY, 11'd1, 32'h0001_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqWidth, AxisY, 11'd0, 32'h0001_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisZ, 11'd0, 32'hFFFF_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisZ, 11'd1, 32'h0001_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqWidth, AxisZ, 11'd0, 32'h0000_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h8000_0000, 32'h0, 32'hFFFF_0000, 1,
      '{1, 0, 0, 0, 0, 0, 0}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 1,
      '{1, 0, FracOne, 0, FracOne, 0, FracOne}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h0, 32'h0000_8000, 32'h0, 1,
      '{1, 0, FracOne, 0, 17'h08000, 0, FracOne}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h0, 32'h0001_0001, 32'h0, 1,
      '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h0, 32'h0, 32'hFFFE_FFFF, 1,
      '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1,
      '{0, 0, 0, 0, 0, 0, 0}},
    '{2'd3,     AxisX, 11'd0, 32'h5, 32'h1, 32'h2, 32'h3, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  2'd3,  11'd0, 32'h5, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisX, 11'd1025, 32'h5, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqWidth, AxisX, 11'd1024, 32'h5, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqNode,  AxisX, 11'd2047, 32'h5, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqWidth, AxisY, 11'd0, 32'hFFFF_0000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h0, 32'h0000_8000, 32'h0001_0000, 1,
      '{1, 0, FracOne, 0, FracOne, 0, FracOne}},
    '{ReqWidth, AxisY, 11'd0, 32'h0000_4000, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0}},
    '{ReqLocate, AxisX, 11'd0, 0, 32'h0, 32'h0000_2000, 32'h0, 1,
      '{1, 0, FracOne, 0, 17'h08000, 0, FracOne}}
  };

  function automatic int unsigned cells_in_use(int ax);
    int unsigned n;
    n = cells_cfg[ax];
    if (n == 0) n = 1;
    if (n > MaxCells) n = MaxCells;
    return n;
  endfunction

  // Signed coordinates compare as unsigned once the sign bit is flipped.
  function automatic logic [31:0] coord_key(logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

  // Binary search for the cell along one axis, then the restoring division.
  function automatic bit locate_on_axis(int ax, logic [31:0] pos,
                                        output logic [9:0] cell_idx,
                                        output logic [16:0] frac);
    int unsigned n, lo, hi, mid;
    logic [31:0] k, base, w;
    logic [63:0] rem;
    logic [16:0] q;
    n = cells_in_use(ax);
    cell_idx = '0;
    frac = '0;
    k = coord_key(pos);
    if (k < coord_key(node_tbl[ax][0]) || k > coord_key(node_tbl[ax][n])) return 1'b0;
    lo = 0;
    hi = n;
    while (hi > lo + 1) begin
      mid = (lo + hi) / 2;
      if (k < coord_key(node_tbl[ax][mid])) hi = mid;
      else lo = mid;
    end
    cell_idx = lo[9:0];
    base = coord_key(node_tbl[ax][lo]);
    w = width_tbl[ax][lo];
    if (k <= base) return 1'b1;
    rem = 64'(k - base);
    if (w == 0 || w[31] || rem >= 64'(w)) begin
      frac = FracOne;
      return 1'b1;
    end
    q = '0;
    for (int i = 0; i < FracBits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= 64'(w)) begin
        rem = rem - 64'(w);
        q[0] = 1'b1;
      end
    end
    frac = q;
    return 1'b1;
  endfunction

  // Applies one request to the mirror; returns 1 when it yields a location.
  function automatic bit apply_request(request_t r, output location_t loc);
    bit ok;
    loc = '{0, 0, 0, 0, 0, 0, 0};
    case (r.req)
      ReqNode: begin
        if (r.axis <= AxisZ && r.idx <= MaxCells) node_tbl[r.axis][r.idx] = r.val;
        return 1'b0;
      end
      ReqWidth: begin
        if (r.axis <= AxisZ && r.idx < MaxCells) width_tbl[r.axis][r.idx] = r.val;
        return 1'b0;
      end
      ReqLocate: begin
        ok = locate_on_axis(0, r.px, loc.cell_x, loc.frac_x);
        if (ok) ok = locate_on_axis(1, r.py, loc.cell_y, loc.frac_y);
        if (ok) ok = locate_on_axis(2, r.pz, loc.cell_z, loc.frac_z);
        if (ok) loc.in_mesh = 1'b1;
        else loc = '{0, 0, 0, 0, 0, 0, 0};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Drives one request from a falling edge and waits until it is taken.
  task automatic send_request(request_t r, bit typed, location_t typed_loc);
    location_t loc;
    if (sender_noisy && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r.req;
    axis_i <= r.axis;
    entry_index_i <= r.idx;
    load_value_i <= r.val;
    pos_x_i <= r.px;
    pos_y_i <= r.py;
    pos_z_i <= r.pz;
    do @(posedge clk_i); while (in_stall_o);
    if (apply_request(r, loc)) pending_locations.push_back(typed ? typed_loc : loc);
    @(negedge clk_i);
  endtask

  task automatic send_plain(request_t r);
    send_request(r, 1'b0, '{0, 0, 0, 0, 0, 0, 0});
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_locations.size() != 0) @(negedge clk_i);
  endtask

  // Registers are written only once the block has gone idle.
  task automatic write_cells(logic [10:0] nx, logic [10:0] ny, logic [10:0] nz);
    logic [10:0] vals [3];
    vals = '{nx, ny, nz};
    drain_results();
    repeat (150) @(negedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[1:0];
      cfg_data_i <= vals[i];
      cells_cfg[i] = vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Loads an ascending mesh with mostly matching widths on one axis.
  task automatic load_mesh_axis(int ax);
    int unsigned n, max_step, step;
    logic [31:0] p, w;
    n = cells_in_use(ax);
    max_step = 32'h6000_0000 / n;
    p = 32'hC000_0000 + $urandom_range(0, 32'h4000_0000);
    for (int i = 0; i <= n; i++) begin
      send_plain('{ReqNode, ax[1:0], i[10:0], p, 0, 0, 0});
      if (i < n) begin
        step = $urandom_range(1, max_step);
        case ($urandom_range(0, 19))
          0: w = 32'h0;
          1: w = 32'h8000_0000 | $urandom;
          2: w = step / 2 + 1;
          3: w = step * 2;
          default: w = step;
        endcase
        send_plain('{ReqWidth, ax[1:0], i[10:0], w, 0, 0, 0});
        p = p + step;
      end
    end
  endtask

  // Picks a coordinate mostly inside the mesh, sometimes on nodes or outside.
  function automatic logic [31:0] pick_coord(int ax);
    int unsigned n, c;
    logic [31:0] k0, k1;
    n = cells_in_use(ax);
    c = $urandom_range(0, n - 1);
    k0 = coord_key(node_tbl[ax][c]);
    k1 = coord_key(node_tbl[ax][c + 1]);
    case ($urandom_range(0, 19))
      0, 1: return node_tbl[ax][$urandom_range(0, n)];
      2: return node_tbl[ax][0] - 1;
      3: return node_tbl[ax][n] + 1;
      4, 5: return $urandom;
      default: begin
        if (k1 >= k0) return coord_key(k0 + $urandom_range(0, k1 - k0));
        return $urandom;
      end
    endcase
  endfunction

  task automatic random_requests(int count, int pause_at);
    request_t r;
    int unsigned ax, i;
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) drain_results();
      ax = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        7: begin
          if ($urandom_range(0, 1) == 0) begin
            i = $urandom_range(0, cells_in_use(ax));
            r = '{ReqNode, ax[1:0], i[10:0], node_tbl[ax][i] + $urandom_range(0, 3), 0, 0, 0};
          end else begin
            i = $urandom_range(0, cells_in_use(ax) - 1);
            r = '{ReqWidth, ax[1:0], i[10:0], $urandom_range(1, 32'h7FFF_FFFF), 0, 0, 0};
          end
        end
        8: begin
          // Any request with random content; in-range node loads keep the stored value.
          r = '{2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 11'($urandom),
                $urandom, $urandom, $urandom, $urandom};
          if (r.req == ReqNode && r.axis <= AxisZ && r.idx <= MaxCells)
            r.val = node_tbl[r.axis][r.idx];
        end
        9: begin
          // Requests that the block ignores.
          case ($urandom_range(0, 2))
            0: r = '{2'd3, 2'($urandom), 11'($urandom), $urandom, $urandom, $urandom, $urandom};
            1: r = '{2'($urandom_range(0, 1)), 2'd3, 11'($urandom), $urandom, 0, 0, 0};
            default: r = '{ReqNode, 2'($urandom_range(0, 2)),
                           11'($urandom_range(MaxCells + 1, 2047)), $urandom, 0, 0, 0};
          endcase
        end
        default: r = '{ReqLocate, 2'($urandom), 11'($urandom), $urandom,
                       pick_coord(0), pick_coord(1), pick_coord(2)};
      endcase
      send_plain(r);
    end
  endtask

  // Receiver side: random stall bursts, one long hold, quiet at the end.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (receiver_noisy && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] act);
    if (expv !== act) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, act);
    end
  endfunction

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    location_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_locations.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual inside=%0b", $time,
                 inside_res_o);
      end else begin
        e = pending_locations.pop_front();
        check_field("inside", 32'(e.in_mesh), 32'(inside_res_o));
        check_field("cell_x", 32'(e.cell_x), 32'(cell_x_o));
        check_field("frac_x", 32'(e.frac_x), 32'(frac_x_o));
        check_field("cell_y", 32'(e.cell_y), 32'(cell_y_o));
        check_field("frac_y", 32'(e.frac_y), 32'(frac_y_o));
        check_field("cell_z", 32'(e.cell_z), 32'(cell_z_o));
        check_field("frac_z", 32'(e.frac_z), 32'(frac_z_o));
      end
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [10:0] phase_cells [NumPhases][3];
    directed_row_t d;
    phase_cells = '{'{11'd4, 11'd7, 11'd2}, '{11'd0, 11'd5, 11'd3},
                    '{11'd12, 11'd1, 11'd5}, '{11'd2, 11'd3, 11'd1},
                    '{11'd9, 11'd1, 11'd6}, '{11'd16, 11'd16, 11'd16}};
    for (int a = 0; a < 3; a++) begin
      cells_cfg[a] = 11'd1;
      foreach (node_tbl[a][i]) node_tbl[a][i] = '0;
      foreach (width_tbl[a][i]) width_tbl[a][i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      d = directed_rows[i];
      send_request('{d.req, d.axis, d.idx, d.val, d.px, d.py, d.pz}, d.typed, d.loc);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == NumPhases - 1) begin
        sender_noisy = 1'b0;
        receiver_noisy = 1'b0;
      end
      write_cells(phase_cells[ph][0], phase_cells[ph][1], phase_cells[ph][2]);
      for (int a = 0; a < 3; a++) load_mesh_axis(a);
      if (ph == 0) long_hold_req = 1'b1;
      random_requests(ItemsPerPhase, (ph == 1) ? ItemsPerPhase / 2 : -1);
    end
    in_valid_i <= 1'b0;

    while (pending_locations.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (error_count == 0 && pending_locations.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/nmcl_pkg.sv
rtl/nmcl_datapath.sv
rtl/nmcl_ctrl.sv
rtl/nonuniform_mesh_cell_locator_core.sv
tb/sv/tb_nonuniform_mesh_cell_locator_core.sv
